@@ hdl/lesp_pkg.sv @@
// Shared types, constants and arithmetic helpers for the linear elastic stress point.
// Used by linear_elastic_stress_point; no dependencies of its own.
`default_nettype none

package lesp_pkg;

  // Root bits of the square root pipelines; the radicand is twice as wide.
  localparam int ROOT_W  = 45;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int IN_W    = 288;
  localparam int OUT_W   = 448;
  localparam int NPROD   = 7;
  localparam int NSQ     = 12;
  localparam int SQ_IN_W = 46;
  localparam int SQ_W    = 92;

  typedef enum logic [2:0] {
    CFG_LAME   = 3'd0,
    CFG_SHEAR  = 3'd1,
    CFG_DIM    = 3'd2,
    CFG_PLANE  = 3'd3,
    CFG_FACTOR = 3'd4
  } cfg_idx_t;

  // Everything that bypasses the von Mises path on its way to the output.
  typedef struct packed {
    logic signed [43:0] sxx;
    logic signed [43:0] syy;
    logic signed [43:0] szz;
    logic signed [43:0] sxy;
    logic signed [43:0] sxz;
    logic signed [43:0] syz;
    logic signed [31:0] ezz;
    logic signed [47:0] hyd;
  } side_t;

  // Partial products of one 46-bit square.
  typedef struct packed {
    logic [43:0] hh;
    logic [45:0] hl;
    logic [47:0] ll;
  } sqpp_t;

  typedef struct packed {
    logic [7:0] q;
    logic [1:0] r;
  } div3_t;

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    mag34 = v[33] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic [45:0] mag46(input logic signed [45:0] v);
    mag46 = v[45] ? 46'(-v) : 46'(v);
  endfunction

  // One byte of long division by three; 683/2048 is exact enough below 768.
  function automatic div3_t div3_step(input logic [1:0] rem, input logic [7:0] chunk);
    logic [9:0]  v;
    logic [19:0] p;
    div3_t       res;
    v     = {rem, chunk};
    p     = 20'(v) * 20'd683;
    res.q = p[18:11];
    res.r = 2'(v - 10'(res.q) * 10'd3);
    div3_step = res;
  endfunction

  function automatic sqpp_t sq_split(input logic [SQ_IN_W-1:0] m);
    logic [21:0] h;
    logic [23:0] l;
    sqpp_t       pp;
    h     = m[45:24];
    l     = m[23:0];
    pp.hh = 44'(h) * 44'(h);
    pp.hl = 46'(h) * 46'(l);
    pp.ll = 48'(l) * 48'(l);
    sq_split = pp;
  endfunction

  function automatic logic [SQ_W-1:0] sq_join(input sqpp_t pp);
    sq_join = (SQ_W'(pp.hh) << 48) + (SQ_W'(pp.hl) << 25) + SQ_W'(pp.ll);
  endfunction

endpackage

`default_nettype wire

@@ hdl/lesp_sqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
// Stand-alone; instantiated by linear_elastic_stress_point.
`default_nettype none

module lesp_sqrt #(
  parameter int ROOT_W = 45
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W-1:0]     root
);

  logic [2*ROOT_W-1:0] rem_q  [ROOT_W-1];
  logic [ROOT_W-1:0]   root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [2*ROOT_W-1:0] rem_in;
    logic [2*ROOT_W-1:0] trial;
    logic [ROOT_W-1:0]   root_in;
    logic                take;

    if (k == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    assign trial = ((2*ROOT_W)'(root_in) << (B + 1)) + ((2*ROOT_W)'(1) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
      end
    end

    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= take ? rem_in - trial : rem_in;
        end
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

`default_nettype wire

@@ hdl/linear_elastic_stress_point.sv @@
// Top level of the linear elastic stress point: strain, Hooke's law, von Mises.
// Depends on lesp_pkg and lesp_sqrt.
`default_nettype none

// One displacement gradient beat in, one stress beat out, one beat per clock
// cycle sustained while the output is not stalled. Twelve stages form the
// strain, the plane-stress correction, the Lame and shear products, the
// squared von Mises terms and the hydrostatic division by three, and the two
// 45-stage square root pipelines (one root bit per stage) follow them. The
// whole pipeline advances together whenever the output register is empty or
// being taken, so s_tready follows m_tready with no bubble. Configuration
// registers must only be written while no beat is in flight; they are read
// directly by the stages that need them.
module linear_elastic_stress_point (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // grad_xx, grad_xy, grad_xz, grad_yx, grad_yy, grad_yz, grad_zx, grad_zy, grad_zz
  input  logic [lesp_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // stress_xx, stress_yy, sigma_zz, stress_xy, stress_xz, stress_yz,
  // strain_zz_out, von_mises_stress, von_mises_strain, hydrostatic_stress, 2 zero bits
  output logic [lesp_pkg::OUT_W-1:0] m_tdata,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data
);

  localparam int LAT = 12 + lesp_pkg::ROOT_W;
  localparam int SDL = lesp_pkg::ROOT_W + 2;

  // Configuration registers.
  logic [31:0] lame_constant;
  logic [31:0] shear_modulus;
  logic [1:0]  dimension;
  logic        plane_stress;
  logic [16:0] plane_stress_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      lame_constant       <= '0;
      shear_modulus       <= '0;
      dimension           <= 2'd3;
      plane_stress        <= 1'b0;
      plane_stress_factor <= '0;
    end else if (cfg_we) begin
      case (lesp_pkg::cfg_idx_t'(cfg_index))
        lesp_pkg::CFG_LAME:   lame_constant       <= cfg_data;
        lesp_pkg::CFG_SHEAR:  shear_modulus       <= cfg_data;
        lesp_pkg::CFG_DIM:    dimension           <= cfg_data[1:0];
        lesp_pkg::CFG_PLANE:  plane_stress        <= cfg_data[0];
        lesp_pkg::CFG_FACTOR: plane_stress_factor <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves as one; the last stage is the output register.
  logic           en;
  logic [LAT-1:0] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Stage 1: row masking by dimension, doubled off-diagonal strains.
  logic signed [31:0] g [9];
  logic [2:0]         row_en;

  always_comb begin
    row_en[0] = dimension != 2'd0;
    row_en[1] = dimension[1];
    row_en[2] = dimension == 2'd3;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        g[r*3+c] = row_en[r] ? $signed(s_tdata[(r*3+c)*32 +: 32]) : 32'sd0;
      end
    end
  end

  logic signed [31:0] exx1, eyy1, ezz1;
  logic signed [32:0] dxy1, dxz1, dyz1, sxy1;
  logic               ps1;

  // Stage 2: plane-stress product factor * (exx + eyy).
  logic signed [31:0] exx2, eyy2, ezz2;
  logic signed [32:0] dxy2, dxz2, dyz2;
  logic signed [50:0] p2;
  logic               ps2;

  // Stage 3: out-of-plane strain, in plane stress rounded, negated and saturated.
  logic signed [31:0] exx3, eyy3, ezz3;
  logic signed [32:0] dxy3, dxz3, dyz3;
  logic [49:0]        pmag;
  logic [50:0]        prnd;
  logic [34:0]        pm;
  logic signed [35:0] pq;
  logic signed [31:0] ezz_ps;

  always_comb begin
    pmag = p2[50] ? 50'(-p2) : p2[49:0];
    prnd = {1'b0, pmag} + 51'h8000;
    pm   = prnd[50:16];
    pq   = p2[50] ? $signed({1'b0, pm}) : -$signed({1'b0, pm});
    if (pq > 36'sd2147483647) begin
      ezz_ps = 32'sh7FFFFFFF;
    end else if (pq < -36'sd2147483648) begin
      ezz_ps = 32'sh80000000;
    end else begin
      ezz_ps = pq[31:0];
    end
  end

  // Stage 4: trace and the seven multiplier operands as sign and magnitude.
  // Operand 0 is the trace (times lame), the rest go with the shear modulus.
  logic signed [33:0] op [lesp_pkg::NPROD];
  logic signed [33:0] et [6];
  logic signed [32:0] dex, dey, dez;

  always_comb begin
    op[0] = $signed({{2{exx3[31]}}, exx3}) + $signed({{2{eyy3[31]}}, eyy3})
          + $signed({{2{ezz3[31]}}, ezz3});
    op[1] = $signed({exx3[31], exx3, 1'b0});
    op[2] = $signed({eyy3[31], eyy3, 1'b0});
    op[3] = $signed({ezz3[31], ezz3, 1'b0});
    op[4] = $signed({dxy3[32], dxy3});
    op[5] = $signed({dxz3[32], dxz3});
    op[6] = $signed({dyz3[32], dyz3});
    dex   = $signed({exx3[31], exx3}) - $signed({eyy3[31], eyy3});
    dey   = $signed({eyy3[31], eyy3}) - $signed({ezz3[31], ezz3});
    dez   = $signed({ezz3[31], ezz3}) - $signed({exx3[31], exx3});
    et[0] = $signed({dex, 1'b0});
    et[1] = $signed({dey, 1'b0});
    et[2] = $signed({dez, 1'b0});
    et[3] = op[4];
    et[4] = op[5];
    et[5] = op[6];
  end

  logic [33:0]        mag4 [lesp_pkg::NPROD];
  logic               neg4 [lesp_pkg::NPROD];
  logic signed [33:0] et4  [6];
  logic signed [31:0] ezz4;

  // Stage 5: modulus times magnitude.
  logic [65:0]        prod5 [lesp_pkg::NPROD];
  logic               neg5  [lesp_pkg::NPROD];
  logic signed [33:0] et5   [6];
  logic signed [31:0] ezz5;

  // Stage 6: rounded half away from zero to Q40.8, sign restored.
  logic [65:0]        rnd6 [lesp_pkg::NPROD];
  logic signed [42:0] term6 [lesp_pkg::NPROD];
  logic signed [33:0] et6   [6];
  logic signed [31:0] ezz6;

  always_comb begin
    for (int i = 0; i < lesp_pkg::NPROD; i++) begin
      rnd6[i] = prod5[i] + 66'h800000;
    end
  end

  // Stage 7: stresses. The sums span 44 bits, so the 48-bit saturation of
  // the output format can never engage and the values are sign-extended.
  lesp_pkg::side_t    side7;
  logic signed [33:0] et7 [6];

  // Stage 8: hydrostatic sum, magnitudes of the von Mises terms.
  logic signed [45:0] hsum;
  logic signed [45:0] vterm [lesp_pkg::NSQ];

  always_comb begin
    hsum = $signed({{2{side7.sxx[43]}}, side7.sxx}) + $signed({{2{side7.syy[43]}}, side7.syy})
         + $signed({{2{side7.szz[43]}}, side7.szz});
    vterm[0] = $signed({{2{side7.sxx[43]}}, side7.sxx}) - $signed({{2{side7.syy[43]}}, side7.syy});
    vterm[1] = $signed({{2{side7.syy[43]}}, side7.syy}) - $signed({{2{side7.szz[43]}}, side7.szz});
    vterm[2] = $signed({{2{side7.szz[43]}}, side7.szz}) - $signed({{2{side7.sxx[43]}}, side7.sxx});
    vterm[3] = $signed({{2{side7.sxy[43]}}, side7.sxy});
    vterm[4] = $signed({{2{side7.sxz[43]}}, side7.sxz});
    vterm[5] = $signed({{2{side7.syz[43]}}, side7.syz});
    for (int i = 0; i < 6; i++) begin
      vterm[6+i] = $signed({{12{et7[i][33]}}, et7[i]});
    end
  end

  lesp_pkg::side_t    side8;
  logic [47:0]        hmag8;
  logic               hneg8;
  logic [45:0]        vmag8 [lesp_pkg::NSQ];

  // Stage 9: square partial products, upper three bytes of the division.
  lesp_pkg::div3_t    dh [3];

  always_comb begin
    dh[0] = lesp_pkg::div3_step(2'd0, hmag8[47:40]);
    dh[1] = lesp_pkg::div3_step(dh[0].r, hmag8[39:32]);
    dh[2] = lesp_pkg::div3_step(dh[1].r, hmag8[31:24]);
  end

  lesp_pkg::side_t    side9;
  lesp_pkg::sqpp_t    pp9 [lesp_pkg::NSQ];
  logic [23:0]        hq9;
  logic [1:0]         hrem9;
  logic [23:0]        hlo9;
  logic               hneg9;

  // Stage 10: squares joined, lower three bytes, signed hydrostatic stress.
  lesp_pkg::div3_t    dl [3];
  logic [47:0]        hq;
  logic signed [47:0] hyd_next;
  lesp_pkg::side_t    side9_hyd;

  always_comb begin
    dl[0]          = lesp_pkg::div3_step(hrem9, hlo9[23:16]);
    dl[1]          = lesp_pkg::div3_step(dl[0].r, hlo9[15:8]);
    dl[2]          = lesp_pkg::div3_step(dl[1].r, hlo9[7:0]);
    hq             = {hq9, dl[0].q, dl[1].q, dl[2].q};
    hyd_next       = hneg9 ? -$signed(hq) : $signed(hq);
    side9_hyd      = side9;
    side9_hyd.hyd  = hyd_next;
  end

  lesp_pkg::side_t        side10;
  logic [lesp_pkg::SQ_W-1:0] sq10 [lesp_pkg::NSQ];

  // Stage 11: sums of normal and shear squares, stress and strain.
  logic [lesp_pkg::SQ_W-1:0] ns11, ts11, ne11, te11;

  // Stage 12: S = n + 6t, halved for stress, divided by eight for strain.
  logic [lesp_pkg::SQ_W-1:0]  vs_sum, ve_sum;
  logic [lesp_pkg::RAD_W-1:0] rad_s12, rad_e12;

  always_comb begin
    vs_sum = ns11 + (ts11 << 2) + (ts11 << 1);
    ve_sum = ne11 + (te11 << 2) + (te11 << 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1
      exx1 <= g[0];
      eyy1 <= g[4];
      ezz1 <= g[8];
      dxy1 <= $signed({g[1][31], g[1]}) + $signed({g[3][31], g[3]});
      dxz1 <= $signed({g[2][31], g[2]}) + $signed({g[6][31], g[6]});
      dyz1 <= $signed({g[5][31], g[5]}) + $signed({g[7][31], g[7]});
      sxy1 <= $signed({g[0][31], g[0]}) + $signed({g[4][31], g[4]});
      ps1  <= (dimension == 2'd2) && plane_stress;
      // Stage 2
      exx2 <= exx1;
      eyy2 <= eyy1;
      ezz2 <= ezz1;
      dxy2 <= dxy1;
      dxz2 <= dxz1;
      dyz2 <= dyz1;
      ps2  <= ps1;
      p2   <= $signed({1'b0, plane_stress_factor}) * sxy1;
      // Stage 3
      exx3 <= exx2;
      eyy3 <= eyy2;
      ezz3 <= ps2 ? ezz_ps : ezz2;
      dxy3 <= dxy2;
      dxz3 <= dxz2;
      dyz3 <= dyz2;
      // Stage 4
      for (int i = 0; i < lesp_pkg::NPROD; i++) begin
        mag4[i] <= lesp_pkg::mag34(op[i]);
        neg4[i] <= op[i][33];
      end
      et4  <= et;
      ezz4 <= ezz3;
      // Stage 5
      prod5[0] <= 66'(lame_constant) * 66'(mag4[0]);
      for (int i = 1; i < lesp_pkg::NPROD; i++) begin
        prod5[i] <= 66'(shear_modulus) * 66'(mag4[i]);
      end
      neg5 <= neg4;
      et5  <= et4;
      ezz5 <= ezz4;
      // Stage 6
      for (int i = 0; i < lesp_pkg::NPROD; i++) begin
        term6[i] <= neg5[i] ? -$signed({1'b0, rnd6[i][65:24]})
                            : $signed({1'b0, rnd6[i][65:24]});
      end
      et6  <= et5;
      ezz6 <= ezz5;
      // Stage 7
      side7.sxx <= $signed({term6[0][42], term6[0]}) + $signed({term6[1][42], term6[1]});
      side7.syy <= $signed({term6[0][42], term6[0]}) + $signed({term6[2][42], term6[2]});
      side7.szz <= $signed({term6[0][42], term6[0]}) + $signed({term6[3][42], term6[3]});
      side7.sxy <= $signed({term6[4][42], term6[4]});
      side7.sxz <= $signed({term6[5][42], term6[5]});
      side7.syz <= $signed({term6[6][42], term6[6]});
      side7.ezz <= ezz6;
      side7.hyd <= '0;
      et7       <= et6;
      // Stage 8
      side8 <= side7;
      hneg8 <= hsum[45];
      hmag8 <= {2'b00, lesp_pkg::mag46(hsum)};
      for (int i = 0; i < lesp_pkg::NSQ; i++) begin
        vmag8[i] <= lesp_pkg::mag46(vterm[i]);
      end
      // Stage 9
      side9 <= side8;
      for (int i = 0; i < lesp_pkg::NSQ; i++) begin
        pp9[i] <= lesp_pkg::sq_split(vmag8[i]);
      end
      hq9   <= {dh[0].q, dh[1].q, dh[2].q};
      hrem9 <= dh[2].r;
      hlo9  <= hmag8[23:0];
      hneg9 <= hneg8;
      // Stage 10
      side10 <= side9_hyd;
      for (int i = 0; i < lesp_pkg::NSQ; i++) begin
        sq10[i] <= lesp_pkg::sq_join(pp9[i]);
      end
      // Stage 11
      ns11 <= sq10[0] + sq10[1] + sq10[2];
      ts11 <= sq10[3] + sq10[4] + sq10[5];
      ne11 <= sq10[6] + sq10[7] + sq10[8];
      te11 <= sq10[9] + sq10[10] + sq10[11];
      // Stage 12
      rad_s12 <= vs_sum[lesp_pkg::RAD_W:1];
      rad_e12 <= lesp_pkg::RAD_W'(ve_sum >> 3);
    end
  end

  // Square roots run beside a delay line carrying the rest of the result.
  logic [lesp_pkg::ROOT_W-1:0] root_s, root_e;

  lesp_sqrt #(.ROOT_W(lesp_pkg::ROOT_W)) u_sqrt_stress (
    .clk  (clk),
    .en   (en),
    .rad  (rad_s12),
    .root (root_s)
  );

  lesp_sqrt #(.ROOT_W(lesp_pkg::ROOT_W)) u_sqrt_strain (
    .clk  (clk),
    .en   (en),
    .rad  (rad_e12),
    .root (root_e)
  );

  lesp_pkg::side_t side_dl [SDL];

  always_ff @(posedge clk) begin
    if (en) begin
      side_dl[0] <= side10;
      for (int i = 1; i < SDL; i++) begin
        side_dl[i] <= side_dl[i-1];
      end
    end
  end

  // Output formatting. The stress root stays below 2^45, so its 47-bit
  // saturation is a zero extension; the strain root can pass 31 bits.
  lesp_pkg::side_t side_out;
  logic [46:0]     vms;
  logic [30:0]     vme;

  assign side_out = side_dl[SDL-1];
  assign vms      = 47'(root_s);
  assign vme      = (|root_e[lesp_pkg::ROOT_W-1:31]) ? 31'h7FFFFFFF : root_e[30:0];

  assign m_tdata = {2'b00, side_out.hyd, vme, vms, side_out.ezz,
                    {{4{side_out.syz[43]}}, side_out.syz},
                    {{4{side_out.sxz[43]}}, side_out.sxz},
                    {{4{side_out.sxy[43]}}, side_out.sxy},
                    {{4{side_out.szz[43]}}, side_out.szz},
                    {{4{side_out.syy[43]}}, side_out.syy},
                    {{4{side_out.sxx[43]}}, side_out.sxx}};

endmodule

`default_nettype wire

@@ hdl/lesp_checker.sv @@
// Port-level checks for linear_elastic_stress_point, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module lesp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [447:0] m_tdata
);

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present right after reset");

  // With the output register empty the block must take a beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  // Back pressure passes straight through the pipeline.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while output stalled");

  // A stalled result beat holds its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

endmodule

bind linear_elastic_stress_point lesp_checker u_lesp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
